>>> hdl/djq_pkg.sv
// ----------------------------------------------------------------------------
// djq_pkg
// Shared types and codes for the duplicate-checking job queue: operation
// kinds, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package djq_pkg;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ID_W-1:0]     ident_t;
  typedef logic [OCC_W-1:0]    occ_t;

  // operation kinds
  localparam kind_t KIND_PUSH = 2'd0;
  localparam kind_t KIND_POP  = 2'd1;
  localparam kind_t KIND_PEEK = 2'd2;

  // result status codes
  localparam status_t ST_OK            = 3'd0;
  localparam status_t ST_INVALID_ARG   = 3'd1;
  localparam status_t ST_INVALID_STATE = 3'd2;
  localparam status_t ST_DUPLICATE     = 3'd3;
  localparam status_t ST_FULL          = 3'd4;
  localparam status_t ST_EMPTY         = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture the input beat
    logic    scan_start;  // arm the duplicate scan at the head
    logic    scan_step;   // advance the scan by one entry
    logic    head_rd;     // read the head entry
    logic    finish;      // write the result register, commit state
    status_t status;      // status of the result
    logic    do_push;     // write ident at the tail
    logic    do_pop;      // drop the head entry
    logic    give_head;   // result carries the head id
  } djq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  id_zero;
    logic  state_bad;
    logic  empty;
    logic  full;
    logic  scan_done;
    logic  scan_hit;
    logic  out_free;
  } djq_stat_t;

endpackage

>>> hdl/djq_dpath.sv
// ----------------------------------------------------------------------------
// djq_dpath
// Datapath of the job queue: input capture, id ring memory, head/tail
// pointers, entry count, duplicate scan pipeline and result register.
// ----------------------------------------------------------------------------
module djq_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  djq_pkg::djq_cmd_t  cmd_i,
  output djq_pkg::djq_stat_t stat_o,
  input  djq_pkg::kind_t     kind_i,
  input  djq_pkg::ident_t    job_ident_i,
  input  logic               state_is_queued_i,
  input  djq_pkg::ident_t    assigned_worker_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output djq_pkg::status_t   status_o,
  output djq_pkg::ident_t    head_ident_o,
  output djq_pkg::occ_t      occupancy_o
);
  import djq_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);

  // ring pointer increment with wrap at the capacity
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    logic [IdxW-1:0] r;
    if (p == LastIdx) r = '0;
    else              r = p + 1'b1;
    return r;
  endfunction

  // captured beat
  kind_t  kind_q;
  ident_t ident_q;
  logic   id_zero_q, state_bad_q;

  // ring state
  ident_t          ring_mem [CAPACITY];
  ident_t          rdata_q;
  logic [IdxW-1:0] head_q, tail_q;
  logic [CntW-1:0] count_q, count_d;

  // scan pipeline
  logic [IdxW-1:0] scan_ptr_q;
  logic [CntW-1:0] scan_left_q;
  logic            cmp_vld_q, hit_q;

  // result register
  logic    out_valid_q;
  status_t status_q;
  ident_t  head_id_q;
  occ_t    occ_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            scan_rd;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= kind_i;
      ident_q     <= job_ident_i;
      id_zero_q   <= (job_ident_i == '0);
      state_bad_q <= !state_is_queued_i || (assigned_worker_i != '0);
    end
  end

  // memory port: one read, one write
  assign scan_rd = cmd_i.scan_step && (scan_left_q != '0);
  assign rd_en   = cmd_i.head_rd || scan_rd;
  assign rd_addr = cmd_i.head_rd ? head_q : scan_ptr_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= ring_mem[rd_addr];
    end
    if (cmd_i.finish && cmd_i.do_push) begin
      ring_mem[tail_q] <= ident_q;
    end
  end

  // count after the committed operation
  always_comb begin
    count_d = count_q;
    if (cmd_i.finish && cmd_i.do_push) count_d = count_q + 1'b1;
    if (cmd_i.finish && cmd_i.do_pop)  count_d = count_q - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.finish && cmd_i.do_push) tail_q <= wrap_inc(tail_q);
      if (cmd_i.finish && cmd_i.do_pop)  head_q <= wrap_inc(head_q);
    end
  end

  // duplicate scan: read one entry a cycle, compare the entry read last cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ptr_q  <= '0;
      scan_left_q <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_ptr_q  <= head_q;
      scan_left_q <= count_q;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_q <= scan_rd;
      if (scan_rd) begin
        scan_ptr_q  <= wrap_inc(scan_ptr_q);
        scan_left_q <= scan_left_q - 1'b1;
      end
      if (cmp_vld_q && (rdata_q == ident_q)) hit_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q  <= cmd_i.status;
      head_id_q <= cmd_i.give_head ? rdata_q : '0;
      occ_q     <= OCC_W'(count_d);
    end
  end

  // status toward the controller
  assign stat_o.kind      = kind_q;
  assign stat_o.id_zero   = id_zero_q;
  assign stat_o.state_bad = state_bad_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= CapCnt);
  assign stat_o.scan_done = (scan_left_q == '0) && !cmp_vld_q;
  assign stat_o.scan_hit  = hit_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign head_ident_o = head_id_q;
  assign occupancy_o  = occ_q;

endmodule

>>> hdl/djq_ctrl.sv
// ----------------------------------------------------------------------------
// djq_ctrl
// Controller of the job queue: sequences capture, checks, the duplicate
// scan, the head read and the commit of one operation at a time.
// ----------------------------------------------------------------------------
module djq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  djq_pkg::djq_stat_t stat_i,
  output djq_pkg::djq_cmd_t  cmd_o
);
  import djq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;

  logic [2:0] state_q, state_d;
  status_t    st_q, st_d;
  logic       ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign ok         = (st_q == ST_OK);

  // next state and commands
  always_comb begin
    state_d         = state_q;
    st_d            = st_q;
    cmd_o           = '0;
    cmd_o.status    = st_q;
    cmd_o.do_push   = ok && (stat_i.kind == KIND_PUSH);
    cmd_o.do_pop    = ok && (stat_i.kind == KIND_POP);
    cmd_o.give_head = ok && ((stat_i.kind == KIND_POP) || (stat_i.kind == KIND_PEEK));
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_FINISH;
        priority if (stat_i.kind == KIND_PUSH) begin
          priority if (stat_i.id_zero) begin
            st_d = ST_INVALID_ARG;
          end else if (stat_i.state_bad) begin
            st_d = ST_INVALID_STATE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else if ((stat_i.kind == KIND_POP) || (stat_i.kind == KIND_PEEK)) begin
          if (stat_i.empty) begin
            st_d = ST_EMPTY;
          end else begin
            cmd_o.head_rd = 1'b1;
            st_d          = ST_OK;
          end
        end else begin
          st_d = ST_INVALID_ARG;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (stat_i.scan_hit) begin
          st_d    = ST_DUPLICATE;
          state_d = S_FINISH;
        end else if (stat_i.scan_done) begin
          st_d    = stat_i.full ? ST_FULL : ST_OK;
          state_d = S_FINISH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

>>> hdl/dedup_fifo_job_queue_core.sv
// ----------------------------------------------------------------------------
// dedup_fifo_job_queue_core
// Ring FIFO of 64-bit job ids that refuses duplicates; push, pop and peek.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per beat:
//   kind_i selects push, pop or peek; job_ident_i, state_is_queued_i and
//   assigned_worker_i matter only for push. Output channel
//   (out_valid_o/out_ready_i) returns one result beat per operation with
//   status_o, head_ident_o and occupancy_o (entries held afterwards).
//   Operations are handled one at a time. Pop, peek and a rejected push
//   skip the duplicate scan; a push that reaches it takes longer as the
//   ring fills, less when a duplicate turns up early, since the scan
//   reads the single ring memory read port one entry per cycle.
//   The next beat is taken the cycle after the result is registered, so a
//   result may still wait in the output register while new work starts.
//   If the receiver stalls, the finished operation holds until the output
//   register frees up, and the input stays blocked meanwhile.
//   Reset empties the queue at once; ring contents are not cleared.
// ----------------------------------------------------------------------------
module dedup_fifo_job_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  djq_pkg::kind_t     kind_i,
  input  djq_pkg::ident_t    job_ident_i,
  input  logic               state_is_queued_i,
  input  djq_pkg::ident_t    assigned_worker_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output djq_pkg::status_t   status_o,
  output djq_pkg::ident_t    head_ident_o,
  output djq_pkg::occ_t      occupancy_o
);
  import djq_pkg::*;

  djq_cmd_t  cmd;
  djq_stat_t stat;

  // sequencing
  djq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, scan and result register
  djq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (kind_i),
    .job_ident_i       (job_ident_i),
    .state_is_queued_i (state_is_queued_i),
    .assigned_worker_i (assigned_worker_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .head_ident_o      (head_ident_o),
    .occupancy_o       (occupancy_o)
  );

endmodule

>>> bench/tb_dedup_fifo_job_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_fifo_job_queue_core
// Self-checking bench for the duplicate-refusing job id ring. A scoreboard
// keeps its own copy of the ring and predicts status, head id and occupancy
// for every accepted operation. Stimulus starts with a directed walk through
// the rejects, empty reads, fill to capacity and full/duplicate ordering,
// then runs random push-heavy and pop-heavy phases over a small id pool so
// duplicates and full rings come up often. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_dedup_fifo_job_queue_core;
  import djq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam kind_t       KIND_UNUSED = 2'd3;
  localparam int          N_RANDOM   = 1850;
  localparam int          N_CALM     = 200;
  localparam int          POOL_SIZE  = 24;
  localparam int          MAX_PRINTS = 50;

  typedef struct {
    status_t status;
    ident_t  head;
    occ_t    occ;
  } queue_answer_t;

  // Predicts each answer of the job ring and checks returned beats in order
  class job_queue_scoreboard;
    ident_t          ring [DEPTH];
    logic [3:0]      head_slot;
    int unsigned     entry_count;
    queue_answer_t   awaited [$];
    int unsigned     mismatches;
    int unsigned     ops_seen;
    int unsigned     status_hits [8];

    function new();
      head_slot   = '0;
      entry_count = 0;
      mismatches  = 0;
      ops_seen    = 0;
      foreach (ring[i]) ring[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // duplicate scan over the held entries, oldest first
    function bit ring_has(ident_t id);
      logic [3:0] pos;
      for (int k = 0; k < entry_count; k++) begin
        pos = head_slot + 4'(k);
        if (ring[pos] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_op(kind_t kind, ident_t id, logic queued, ident_t worker);
      queue_answer_t ans;
      logic [3:0]    tail;
      ans.head = '0;
      case (kind)
        KIND_PUSH: begin
          if (id == '0) ans.status = ST_INVALID_ARG;
          else if (queued !== 1'b1 || worker != '0) ans.status = ST_INVALID_STATE;
          else if (ring_has(id)) ans.status = ST_DUPLICATE;
          else if (entry_count >= DEPTH) ans.status = ST_FULL;
          else begin
            tail = head_slot + 4'(entry_count);
            ring[tail] = id;
            entry_count++;
            ans.status = ST_OK;
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (entry_count == 0) ans.status = ST_EMPTY;
          else begin
            ans.head   = ring[head_slot];
            ans.status = ST_OK;
            if (kind == KIND_POP) begin
              ring[head_slot] = '0;
              head_slot++;
              entry_count--;
            end
          end
        end
        default: ans.status = ST_INVALID_ARG;
      endcase
      ans.occ = occ_t'(entry_count);
      status_hits[ans.status]++;
      ops_seen++;
      awaited.push_back(ans);
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(status_t st, ident_t hd, occ_t oc);
      queue_answer_t exp_ans;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (status %0d)", st));
        return;
      end
      exp_ans = awaited.pop_front();
      if (st !== exp_ans.status)
        report_mismatch($sformatf("status %0d, want %0d", st, exp_ans.status));
      if (hd !== exp_ans.head)
        report_mismatch($sformatf("head id %h, want %h", hd, exp_ans.head));
      if (oc !== exp_ans.occ)
        report_mismatch($sformatf("occupancy %0d, want %0d", oc, exp_ans.occ));
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  kind_t    kind_i;
  ident_t   job_ident_i;
  logic     state_is_queued_i;
  ident_t   assigned_worker_i;
  logic     out_valid_o;
  logic     out_ready_i;
  status_t  status_o;
  ident_t   head_ident_o;
  occ_t     occupancy_o;

  bit       calm;
  ident_t   id_pool [POOL_SIZE];

  job_queue_scoreboard sb = new();

  dedup_fifo_job_queue_core #(.CAPACITY(DEPTH)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .job_ident_i       (job_ident_i),
    .state_is_queued_i (state_is_queued_i),
    .assigned_worker_i (assigned_worker_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .head_ident_o      (head_ident_o),
    .occupancy_o       (occupancy_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Beat monitor: results first, then the operation taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, head_ident_o, occupancy_o);
      if (in_valid_i && in_ready_o)
        sb.note_op(kind_i, job_ident_i, state_is_queued_i, assigned_worker_i);
    end
  end

  // Optional idle burst, then one operation held until taken
  task automatic issue_op(kind_t k, ident_t id, logic queued, ident_t worker);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= k;
    job_ident_i       <= id;
    state_is_queued_i <= queued;
    assigned_worker_i <= worker;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One random operation; push odds depend on the current phase
  task automatic random_op(bit push_heavy);
    int     roll;
    int     flavor;
    ident_t junk;
    ident_t worker;
    roll   = $urandom_range(0, 99);
    flavor = $urandom_range(0, 9);
    junk   = {$urandom, $urandom};
    worker = {$urandom, $urandom};
    if (worker == '0) worker = ident_t'(1);
    if (roll < (push_heavy ? 75 : 30)) begin
      case (flavor)
        0: issue_op(KIND_PUSH, '0, 1'($urandom), junk);
        1: issue_op(KIND_PUSH, id_pool[$urandom_range(0, POOL_SIZE-1)], 1'b0, '0);
        2: issue_op(KIND_PUSH, id_pool[$urandom_range(0, POOL_SIZE-1)], 1'b1, worker);
        3: issue_op(KIND_PUSH, (junk == '0) ? ident_t'(7) : junk, 1'b1, '0);
        default: issue_op(KIND_PUSH, id_pool[$urandom_range(0, POOL_SIZE-1)], 1'b1, '0);
      endcase
    end else if (roll < 98) begin
      issue_op(($urandom_range(0, 1) == 0) ? KIND_POP : KIND_PEEK, junk, 1'($urandom),
               worker);
    end else begin
      issue_op(KIND_UNUSED, junk, 1'($urandom), junk);
    end
  endtask

  // Receiver: random stall bursts, steady ready once things calm down
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      if (calm) @(posedge clk_i);
      else begin
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        if ($urandom_range(0, 1) == 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int phase_left;
    bit push_heavy;
    in_valid_i        = 1'b0;
    kind_i            = KIND_PUSH;
    job_ident_i       = '0;
    state_is_queued_i = 1'b0;
    assigned_worker_i = '0;
    out_ready_i       = 1'b0;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    phase_left        = 0;
    push_heavy        = 1'b0;
    foreach (id_pool[i]) begin
      id_pool[i] = {$urandom, $urandom};
      if (id_pool[i] == '0) id_pool[i] = ident_t'(i + 1);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty reads and the push reject order
    issue_op(KIND_POP, '0, 1'b0, '0);
    issue_op(KIND_PEEK, '1, 1'b1, '1);
    issue_op(KIND_PUSH, '0, 1'b0, '1);
    issue_op(KIND_PUSH, '1, 1'b0, '0);
    issue_op(KIND_PUSH, ident_t'(5), 1'b1, '1);
    issue_op(KIND_PUSH, '1, 1'b1, '0);
    issue_op(KIND_PUSH, '1, 1'b1, '0);
    // fill to capacity, then full vs duplicate precedence
    for (int i = 1; i < DEPTH; i++)
      issue_op(KIND_PUSH, {32'(i), 32'h5A5A_0000 | 32'(i)}, 1'b1, '0);
    issue_op(KIND_PUSH, 64'h8000_0000_0000_0000, 1'b1, '0);
    issue_op(KIND_PUSH, '1, 1'b1, '0);
    issue_op(KIND_UNUSED, '1, 1'b1, '1);
    issue_op(KIND_PEEK, '0, 1'b0, '0);
    issue_op(KIND_POP, '0, 1'b0, '0);

    // random phases, each picked at random as push-heavy or pop-heavy
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) calm = 1'b1;
      if (phase_left == 0) begin
        push_heavy = 1'($urandom_range(0, 1));
        phase_left = $urandom_range(10, 50);
      end
      phase_left--;
      random_op(push_heavy);
    end
    in_valid_i <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Checked %0d operations across fill/drain phases and handshake stalls.",
             sb.ops_seen);
    $display("Status mix: ok %0d, bad arg %0d, bad state %0d, dup %0d, full %0d, empty %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_INVALID_ARG],
             sb.status_hits[ST_INVALID_STATE], sb.status_hits[ST_DUPLICATE],
             sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY]);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("Timeout with %0d results outstanding", sb.awaited.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
